>>> sv/line_follow_pd_steering_macros.svh
// Assertion macros used by the port-level checker file of the steering block.
`ifndef LINE_FOLLOW_PD_STEERING_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LFPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfpd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LFPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfpd assertion failed");

`endif

>>> sv/lfpd_pkg.sv
// Types, codes and sizes shared by the PD line-follow steering block.
package lfpd_pkg;

  localparam int RUN_BITS  = 16;
  localparam int DIV_W     = RUN_BITS + 1;
  localparam int DIFF_W    = 4;
  localparam int GAIN_W    = 8;
  localparam int PROD_W    = GAIN_W + DIFF_W;
  localparam int PROP_W    = GAIN_W + 3;
  localparam int CORR_W    = 14;
  localparam int SPEED_W   = 9;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int MUL_STEPS = DIFF_W;

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};
  localparam logic [RUN_BITS-1:0] RUN_ONE = RUN_BITS'(1);

  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_ALIGN_R = 2'd1;
  localparam logic [1:0] FUNC_ALIGN_L = 2'd2;

  localparam logic [1:0] STAT_DRIVE = 2'd0;
  localparam logic [1:0] STAT_EDGE  = 2'd1;
  localparam logic [1:0] STAT_NODE  = 2'd2;
  localparam logic [1:0] STAT_ALIGN = 2'd3;

  localparam logic [1:0] NODE_NONE  = 2'd0;
  localparam logic [1:0] NODE_BOTH  = 2'd1;
  localparam logic [1:0] NODE_RIGHT = 2'd2;
  localparam logic [1:0] NODE_LEFT  = 2'd3;

  localparam logic [1:0] REG_KP    = 2'd0;
  localparam logic [1:0] REG_KD    = 2'd1;
  localparam logic [1:0] REG_BASE  = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  localparam logic [GAIN_W-1:0] KP_RESET    = 8'd10;
  localparam logic [GAIN_W-1:0] KD_RESET    = 8'd20;
  localparam logic [GAIN_W-1:0] BASE_RESET  = 8'd100;
  localparam logic [GAIN_W-1:0] LIMIT_RESET = 8'd255;

  localparam logic signed [3:0] ERR_ZERO     = 4'sd0;
  localparam logic signed [3:0] ERR_POS_ONE  = 4'sd1;
  localparam logic signed [3:0] ERR_NEG_ONE  = -4'sd1;
  localparam logic signed [3:0] ERR_LOST_POS = 4'sd5;
  localparam logic signed [3:0] ERR_LOST_NEG = -4'sd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CORR,
    ST_VEL,
    ST_SPEED,
    ST_PUSH
  } state_t;

endpackage

>>> sv/line_follow_pd_steering.sv
// Top level of the PD line-follow steering block.
// One item is taken at a time. An edge, node or realign item goes from acceptance
// straight to the output-register load, and the block is then ready for the next item.
// A sensor sample first runs a bit-serial multiply of the derivative gain by the
// error change over the four bits of that change, then a restoring divide by the sum
// of the prior and current run counts, one quotient bit a cycle over the twelve bits of
// the product, then correction, velocity override and saturation, each registered in its
// own state, before the output register is loaded.
// If the output register still holds an item that has not been taken, the load waits.
// The next item is accepted while the previous one waits in the output register.
module line_follow_pd_steering
  import lfpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [GAIN_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic                      edge_seen,
  input  logic                      line_right,
  input  logic                      line_left,
  input  logic                      node_right,
  input  logic                      node_left,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [1:0]                node_kind,
  output logic signed [SPEED_W-1:0] right_speed,
  output logic signed [SPEED_W-1:0] left_speed
);

  state_t state, state_next;

  logic [GAIN_W-1:0] kp_gain, kd_gain, base_velocity, speed_limit;

  logic signed [3:0]   last_err, prior_err;
  logic [RUN_BITS-1:0] prior_run, cur_run;

  logic [CNT_W-1:0]        cnt;
  logic [PROD_W-1:0]       mul_acc, mul_mcand;
  logic [DIFF_W-1:0]       mul_mplier;
  logic [DIV_W-1:0]        divisor, rem;
  logic [PROD_W-1:0]       quot;
  logic [PROP_W-1:0]       prop_mag;
  logic                    prop_neg, der_neg;
  logic signed [CORR_W-1:0] corr, vel;

  logic [1:0]                res_status, res_kind;
  logic signed [SPEED_W-1:0] res_right, res_left;

  logic accept, load_out, sample_item, align_item;
  logic mul_last, div_last;

  logic signed [3:0]   err_new, prior_err_upd;
  logic [RUN_BITS-1:0] prior_run_upd, cur_run_upd;
  logic signed [4:0]   diff;
  logic [4:0]          diff_abs;
  logic [DIV_W-1:0]    div_sum;
  logic [PROD_W-1:0]   mul_acc_next;
  logic [DIV_W:0]      trial;
  logic                trial_ge;
  logic signed [CORR_W-1:0] prop_s, der_s, lim_s, vel_pick;
  logic signed [CORR_W-1:0] right_raw, left_raw, right_sat, left_sat;

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = sample_item ? ST_MUL : ST_PUSH;
      ST_MUL:   if (mul_last) state_next = ST_DIV;
      ST_DIV:   if (div_last) state_next = ST_CORR;
      ST_CORR:  state_next = ST_VEL;
      ST_VEL:   state_next = ST_SPEED;
      ST_SPEED: state_next = ST_PUSH;
      ST_PUSH:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE) && !rst;
    load_out = (state == ST_PUSH) && (!out_valid || out_ready);
  end

  assign accept      = in_valid && in_ready;
  assign align_item  = (func == FUNC_ALIGN_R) || (func == FUNC_ALIGN_L);
  assign sample_item = !align_item && !edge_seen && !node_right && !node_left;
  assign mul_last    = (cnt == CNT_W'(MUL_STEPS - 1));
  assign div_last    = (cnt == CNT_W'(PROD_W - 1));

  // line error and history update
  always_comb begin
    if (line_left && line_right) err_new = ERR_ZERO;
    else if (line_left) err_new = ERR_NEG_ONE;
    else if (line_right) err_new = ERR_POS_ONE;
    else err_new = (last_err > ERR_ZERO) ? ERR_LOST_POS : ERR_LOST_NEG;

    if (err_new != last_err) begin
      prior_err_upd = last_err;
      prior_run_upd = cur_run;
      cur_run_upd   = RUN_ONE;
    end else begin
      prior_err_upd = prior_err;
      prior_run_upd = prior_run;
      cur_run_upd   = cur_run;
    end

    div_sum  = {1'b0, prior_run_upd} + {1'b0, cur_run_upd};
    diff     = {err_new[3], err_new} - {prior_err_upd[3], prior_err_upd};
    diff_abs = diff[4] ? 5'(-diff) : 5'(diff);
  end

  assign mul_acc_next = mul_mplier[0] ? (mul_acc + mul_mcand) : mul_acc;
  assign trial        = {rem, quot[PROD_W-1]};
  assign trial_ge     = (trial >= {1'b0, divisor});

  // correction and speed arithmetic
  always_comb begin
    prop_s = prop_neg ? -$signed({3'b000, prop_mag}) : $signed({3'b000, prop_mag});
    der_s  = der_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    lim_s  = $signed({{(CORR_W-GAIN_W){1'b0}}, speed_limit});

    vel_pick = $signed({{(CORR_W-GAIN_W){1'b0}}, base_velocity});
    if (vel_pick - corr < -lim_s) vel_pick = -lim_s;
    if (vel_pick + corr > lim_s) vel_pick = lim_s;

    right_raw = vel - corr;
    left_raw  = vel + corr;
    if (right_raw > lim_s) right_sat = lim_s;
    else if (right_raw < -lim_s) right_sat = -lim_s;
    else right_sat = right_raw;
    if (left_raw > lim_s) left_sat = lim_s;
    else if (left_raw < -lim_s) left_sat = -lim_s;
    else left_sat = left_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      kp_gain       <= KP_RESET;
      kd_gain       <= KD_RESET;
      base_velocity <= BASE_RESET;
      speed_limit   <= LIMIT_RESET;
      last_err      <= ERR_ZERO;
      prior_err     <= ERR_ZERO;
      prior_run     <= RUN_ONE;
      cur_run       <= '0;
      cnt           <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_KP:    kp_gain       <= cfg_data;
          REG_KD:    kd_gain       <= cfg_data;
          REG_BASE:  base_velocity <= cfg_data;
          REG_LIMIT: speed_limit   <= cfg_data;
          default:   kp_gain       <= kp_gain;
        endcase
      end

      if (accept) begin
        cnt <= '0;
        if (align_item) begin
          last_err  <= (func == FUNC_ALIGN_R) ? ERR_POS_ONE : ERR_NEG_ONE;
          prior_err <= (func == FUNC_ALIGN_R) ? ERR_POS_ONE : ERR_NEG_ONE;
          prior_run <= RUN_ONE;
          cur_run   <= '0;
        end else if (sample_item) begin
          last_err  <= err_new;
          prior_err <= prior_err_upd;
          prior_run <= prior_run_upd;
          cur_run   <= (cur_run_upd == RUN_MAX) ? cur_run_upd : cur_run_upd + RUN_ONE;
        end
      end

      if (state == ST_MUL || state == ST_DIV) begin
        cnt <= (mul_last && state == ST_MUL) ? '0 : cnt + CNT_W'(1);
      end

      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      res_kind  <= NODE_NONE;
      res_right <= '0;
      res_left  <= '0;
      if (align_item) begin
        res_status <= STAT_ALIGN;
      end else if (edge_seen) begin
        res_status <= STAT_EDGE;
      end else if (node_right || node_left) begin
        res_status <= STAT_NODE;
        if (node_right && node_left) res_kind <= NODE_BOTH;
        else if (node_right) res_kind <= NODE_RIGHT;
        else res_kind <= NODE_LEFT;
      end else begin
        res_status <= STAT_DRIVE;
      end

      prop_neg <= err_new[3];
      if (err_new == ERR_LOST_POS || err_new == ERR_LOST_NEG) begin
        prop_mag <= {1'b0, kp_gain, 2'b00} + {3'b000, kp_gain};
      end else if (err_new == ERR_ZERO) begin
        prop_mag <= '0;
      end else begin
        prop_mag <= {3'b000, kp_gain};
      end

      der_neg    <= diff[4];
      divisor    <= (div_sum == '0) ? DIV_W'(1) : div_sum;
      mul_acc    <= '0;
      mul_mcand  <= {{(PROD_W-GAIN_W){1'b0}}, kd_gain};
      mul_mplier <= diff_abs[DIFF_W-1:0];
    end

    unique case (state)
      ST_MUL: begin
        mul_acc    <= mul_acc_next;
        mul_mcand  <= {mul_mcand[PROD_W-2:0], 1'b0};
        mul_mplier <= {1'b0, mul_mplier[DIFF_W-1:1]};
        if (mul_last) begin
          quot <= mul_acc_next;
          rem  <= '0;
        end
      end
      ST_DIV: begin
        rem  <= trial_ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
        quot <= {quot[PROD_W-2:0], trial_ge};
      end
      ST_CORR:  corr <= prop_s + der_s;
      ST_VEL:   vel  <= vel_pick;
      ST_SPEED: begin
        res_right <= right_sat[SPEED_W-1:0];
        res_left  <= left_sat[SPEED_W-1:0];
      end
      default: begin
      end
    endcase

    if (load_out) begin
      status      <= res_status;
      node_kind   <= res_kind;
      right_speed <= res_right;
      left_speed  <= res_left;
    end
  end

endmodule

>>> sv/lfpd_checker.sv
// Port-level checker for the steering block and its bind.
`include "line_follow_pd_steering_macros.svh"

module lfpd_checker
  import lfpd_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic [1:0]                node_kind,
  input logic signed [SPEED_W-1:0] right_speed,
  input logic signed [SPEED_W-1:0] left_speed
);

  `LFPD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
  `LFPD_ASSERT_NOW(a_stop_zero, out_valid && status != STAT_DRIVE,
                   right_speed == '0 && left_speed == '0)
  `LFPD_ASSERT_NOW(a_kind_node, out_valid && status != STAT_NODE, node_kind == NODE_NONE)
  `LFPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(status) && $stable(right_speed) && $stable(left_speed))

endmodule

bind line_follow_pd_steering lfpd_checker u_lfpd_checker (.*);

>>> sim/line_follow_pd_steering_checker.sv
// Checker for the PD steering block: watches both channels, predicts wheel commands, compares.
module steer_checker
  import lfpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [GAIN_W-1:0]         cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                func,
  input  logic                      edge_seen,
  input  logic                      line_right,
  input  logic                      line_left,
  input  logic                      node_right,
  input  logic                      node_left,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [1:0]                status,
  input  logic [1:0]                node_kind,
  input  logic signed [SPEED_W-1:0] right_speed,
  input  logic signed [SPEED_W-1:0] left_speed,
  output int                        mismatches,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]                status;
    logic [1:0]                kind;
    logic signed [SPEED_W-1:0] right;
    logic signed [SPEED_W-1:0] left;
  } wheel_cmd_t;

  logic [GAIN_W-1:0]   kp_gain, kd_gain, base_velocity, speed_limit;
  logic signed [3:0]   last_err, prior_err;
  logic [RUN_BITS-1:0] prior_run, cur_run;
  wheel_cmd_t          wheel_cmds_q[$];

  function automatic int limit_speed(int s, int lim);
    if (s > lim) return lim;
    if (s < -lim) return -lim;
    return s;
  endfunction

  function automatic wheel_cmd_t predict_wheels(logic [1:0] f, logic e, logic lr, logic ll,
                                                logic nr, logic nl);
    wheel_cmd_t cmd;
    int         err, prop, der, corr, v, lim;
    longint     dv;
    cmd = '{STAT_DRIVE, NODE_NONE, '0, '0};
    if (f == FUNC_ALIGN_R || f == FUNC_ALIGN_L) begin
      last_err   = (f == FUNC_ALIGN_R) ? ERR_POS_ONE : ERR_NEG_ONE;
      prior_err  = last_err;
      prior_run  = RUN_ONE;
      cur_run    = '0;
      cmd.status = STAT_ALIGN;
      return cmd;
    end
    if (e) begin
      cmd.status = STAT_EDGE;
      return cmd;
    end
    if (nr || nl) begin
      cmd.status = STAT_NODE;
      cmd.kind   = (nr && nl) ? NODE_BOTH : (nr ? NODE_RIGHT : NODE_LEFT);
      return cmd;
    end
    if (ll && lr) err = 0;
    else if (ll) err = -1;
    else if (lr) err = 1;
    else err = (last_err > 0) ? 5 : -5;
    if (err != int'(last_err)) begin
      prior_err = last_err;
      prior_run = cur_run;
      cur_run   = RUN_ONE;
    end
    last_err = 4'(err);
    prop = int'(kp_gain) * err;
    dv   = longint'(prior_run) + longint'(cur_run);
    if (dv <= 0) dv = 1;
    der  = int'(longint'(int'(kd_gain) * (err - int'(prior_err))) / dv);
    corr = prop + der;
    if (cur_run != RUN_MAX) cur_run = cur_run + 1'b1;
    lim = int'(speed_limit);
    v   = int'(base_velocity);
    if (v - corr < -lim) v = -lim;
    if (v + corr > lim) v = lim;
    cmd.right = SPEED_W'(limit_speed(v - corr, lim));
    cmd.left  = SPEED_W'(limit_speed(v + corr, lim));
    return cmd;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    wheel_cmd_t want;
    if (rst) begin
      kp_gain       = KP_RESET;
      kd_gain       = KD_RESET;
      base_velocity = BASE_RESET;
      speed_limit   = LIMIT_RESET;
      last_err      = ERR_ZERO;
      prior_err     = ERR_ZERO;
      prior_run     = RUN_ONE;
      cur_run       = '0;
      wheel_cmds_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KP:    kp_gain       = cfg_data;
          REG_KD:    kd_gain       = cfg_data;
          REG_BASE:  base_velocity = cfg_data;
          REG_LIMIT: speed_limit   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (wheel_cmds_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = wheel_cmds_q[0];
          wheel_cmds_q.delete(0);
          check_field("status", int'(status), int'(want.status));
          check_field("node_kind", int'(node_kind), int'(want.kind));
          check_field("right_speed", int'(right_speed), int'(want.right));
          check_field("left_speed", int'(left_speed), int'(want.left));
        end
      end
      if (in_valid && in_ready)
        wheel_cmds_q.push_back(predict_wheels(func, edge_seen, line_right, line_left,
                                              node_right, node_left));
    end
    pending = wheel_cmds_q.size();
  end

endmodule

>>> sim/testbench.sv
// Top of the steering testbench: clock, reset, stimulus, receiver and verdict.
module testbench;
  import lfpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [1:0]                cfg_index;
  logic [GAIN_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                func;
  logic                      edge_seen;
  logic                      line_right;
  logic                      line_left;
  logic                      node_right;
  logic                      node_left;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                status;
  logic [1:0]                node_kind;
  logic signed [SPEED_W-1:0] right_speed;
  logic signed [SPEED_W-1:0] left_speed;
  int                        mismatches;
  int                        pending;
  bit                        calm;
  bit                        hold_req;
  logic [1:0]                track;

  line_follow_pd_steering i_dut (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .func, .edge_seen, .line_right, .line_left,
    .node_right, .node_left,
    .out_valid, .out_ready, .status, .node_kind, .right_speed, .left_speed
  );

  steer_checker i_checker (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .func, .edge_seen, .line_right, .line_left,
    .node_right, .node_left,
    .out_valid, .out_ready, .status, .node_kind, .right_speed, .left_speed,
    .mismatches, .pending
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = calm ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  task automatic offer(input logic [1:0] f, input logic e, input logic lr, input logic ll,
                       input logic nr, input logic nl);
    if (!calm) begin
      while ($urandom_range(99) < 10) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid   = 1'b1;
    func       = f;
    edge_seen  = e;
    line_right = lr;
    line_left  = ll;
    node_right = nr;
    node_left  = nl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly plain samples with a persistent line pattern so runs build up
  task automatic offer_random();
    int         pick;
    logic [1:0] f;
    logic [1:0] nodes;
    logic       e;
    pick  = $urandom_range(99);
    f     = ($urandom_range(9) == 0) ? FUNC_SPARE : FUNC_SAMPLE;
    e     = 1'b0;
    nodes = 2'b00;
    if ($urandom_range(99) < 30) track = 2'($urandom_range(3));
    if (pick < 6) begin
      f     = (pick < 3) ? FUNC_ALIGN_R : FUNC_ALIGN_L;
      e     = 1'($urandom_range(1));
      nodes = 2'($urandom_range(3));
    end else if (pick < 12) begin
      e     = 1'b1;
      nodes = 2'($urandom_range(3));
    end else if (pick < 22) begin
      nodes = 2'($urandom_range(1, 3));
    end
    offer(f, e, track[0], track[1], nodes[0], nodes[1]);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
  endtask

  task automatic write_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                            input logic [GAIN_W-1:0] base, input logic [GAIN_W-1:0] lim);
    put_reg(REG_KP, kp);
    put_reg(REG_KD, kd);
    put_reg(REG_BASE, base);
    put_reg(REG_LIMIT, lim);
    cfg_wr_en = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
                           input logic [GAIN_W-1:0] base, input logic [GAIN_W-1:0] lim,
                           input int n, input bit hold);
    drain();
    write_regs(kp, kd, base, lim);
    if (hold) hold_req = 1'b1;
    repeat (n) offer_random();
  endtask

  initial begin
    rst        = 1'b1;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_KP;
    cfg_data   = '0;
    in_valid   = 1'b0;
    func       = FUNC_SAMPLE;
    edge_seen  = 1'b0;
    line_right = 1'b0;
    line_left  = 1'b0;
    node_right = 1'b0;
    node_left  = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    track      = 2'b11;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: line patterns, lost line both ways, edge, nodes, realign, spare selector
    offer(FUNC_SAMPLE,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    offer(FUNC_SPARE,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    offer(FUNC_SPARE,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    offer(FUNC_SPARE,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(FUNC_ALIGN_R, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    offer(FUNC_ALIGN_L, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE,  1'b0, 1'b1, 1'b1, 1'b0, 1'b0);

    run_phase(8'd0, 8'd0, 8'd0, 8'd0, 170, 1'b0);
    run_phase(8'd255, 8'd255, 8'd255, 8'd255, 170, 1'b1);
    run_phase(8'd255, 8'd255, 8'd0, 8'd255, 170, 1'b0);
    run_phase(8'd0, 8'd255, 8'd255, 8'd1, 170, 1'b0);
    run_phase(8'd128, 8'd0, 8'd200, 8'd100, 170, 1'b0);
    calm = 1'b1;
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 170, 1'b0);
    calm = 1'b0;
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 170, 1'b0);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(40)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 170, 1'b0);

    // hold the line centered for a long run, then swing it both ways
    calm = 1'b1;
    drain();
    write_regs(8'd1, 8'd255, 8'd100, 8'd200);
    offer(FUNC_ALIGN_R, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    repeat (20) offer(FUNC_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    offer(FUNC_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    offer(FUNC_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    offer(FUNC_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    calm = 1'b0;

    drain();
    repeat (25) @(negedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
